// ----- rtl/core/tqm_pkg.sv -----
// tqm_pkg: item types and fixed field widths for the tetrahedron quality metric
// no dependencies; used by every module under rtl/core
`default_nettype none
package tqm_pkg;

   localparam int COORD_W = 16;
   localparam int SIXV_W  = 55;
   localparam int QUAL_W  = 47;

   typedef struct packed {
      logic signed [COORD_W-1:0] v0_x;
      logic signed [COORD_W-1:0] v0_y;
      logic signed [COORD_W-1:0] v0_z;
      logic signed [COORD_W-1:0] v1_x;
      logic signed [COORD_W-1:0] v1_y;
      logic signed [COORD_W-1:0] v1_z;
      logic signed [COORD_W-1:0] v2_x;
      logic signed [COORD_W-1:0] v2_y;
      logic signed [COORD_W-1:0] v2_z;
      logic signed [COORD_W-1:0] v3_x;
      logic signed [COORD_W-1:0] v3_y;
      logic signed [COORD_W-1:0] v3_z;
   } req_type;

   typedef struct packed {
      logic [SIXV_W-1:0] six_volume;
      logic [QUAL_W-1:0] quality;
      logic              degenerate;
   } rsp_type;

endpackage
`default_nettype wire

// ----- rtl/core/tqm_geom.sv -----
// tqm_geom: five-stage edge, triple product and squared edge sum pipeline
// depends on tqm_pkg
`default_nettype none
module tqm_geom #(
   parameter int COORD_BITS = 16,
   localparam int SUM_W = 2*(COORD_BITS+1)+4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire tqm_pkg::req_type          in_data,
   output logic                           out_valid,
   output logic [tqm_pkg::SIXV_W-1:0]     out_top,
   output logic [SUM_W-1:0]               out_sum
);
   localparam int DW   = COORD_BITS + 1;
   localparam int PW   = 2*DW;
   localparam int CW   = 2*DW + 1;
   localparam int ESW  = PW + 2;
   localparam int TW   = 3*DW + 1;
   localparam int AW   = 3*DW + 3;

   logic signed [COORD_BITS-1:0] p [0:3][0:2];

   // stage 1: edge vectors
   logic signed [DW-1:0] e_in [0:5][0:2];
   logic signed [DW-1:0] e_ff [0:5][0:2];
   logic                 v1_ff;

   // stage 2: cross partials and squares
   logic signed [PW-1:0] m_in  [0:5];
   logic signed [PW-1:0] m_ff  [0:5];
   logic signed [PW-1:0] sq_in [0:5][0:2];
   logic signed [PW-1:0] sq_ff [0:5][0:2];
   logic signed [DW-1:0] e1a_ff [0:2];
   logic                 v2_ff;

   // stage 3: cross product and per-edge squared lengths
   logic signed [CW-1:0] c_in  [0:2];
   logic signed [CW-1:0] c_ff  [0:2];
   logic [ESW-1:0]       es_in [0:5];
   logic [ESW-1:0]       es_ff [0:5];
   logic signed [DW-1:0] e1b_ff [0:2];
   logic                 v3_ff;

   // stage 4: dot product terms and total squared length sum
   logic signed [TW-1:0] t_in [0:2];
   logic signed [TW-1:0] t_ff [0:2];
   logic [SUM_W-1:0]     sum_in;
   logic [SUM_W-1:0]     sum4_ff;
   logic                 v4_ff;

   // stage 5: triple product magnitude
   logic signed [AW-1:0]        tp;
   logic [AW-1:0]               tp_abs;
   logic [tqm_pkg::SIXV_W-1:0]  top_ff;
   logic [SUM_W-1:0]            sum5_ff;
   logic                        v5_ff;

   always_comb begin
      p[0][0] = in_data.v0_x[COORD_BITS-1:0];
      p[0][1] = in_data.v0_y[COORD_BITS-1:0];
      p[0][2] = in_data.v0_z[COORD_BITS-1:0];
      p[1][0] = in_data.v1_x[COORD_BITS-1:0];
      p[1][1] = in_data.v1_y[COORD_BITS-1:0];
      p[1][2] = in_data.v1_z[COORD_BITS-1:0];
      p[2][0] = in_data.v2_x[COORD_BITS-1:0];
      p[2][1] = in_data.v2_y[COORD_BITS-1:0];
      p[2][2] = in_data.v2_z[COORD_BITS-1:0];
      p[3][0] = in_data.v3_x[COORD_BITS-1:0];
      p[3][1] = in_data.v3_y[COORD_BITS-1:0];
      p[3][2] = in_data.v3_z[COORD_BITS-1:0];
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e_in[0][k] = DW'(p[1][k]) - DW'(p[0][k]);
         e_in[1][k] = DW'(p[2][k]) - DW'(p[0][k]);
         e_in[2][k] = DW'(p[3][k]) - DW'(p[0][k]);
         e_in[3][k] = DW'(p[1][k]) - DW'(p[2][k]);
         e_in[4][k] = DW'(p[1][k]) - DW'(p[3][k]);
         e_in[5][k] = DW'(p[2][k]) - DW'(p[3][k]);
      end
   end

   always_comb begin
      m_in[0] = PW'(e_ff[1][1]) * PW'(e_ff[2][2]);
      m_in[1] = PW'(e_ff[1][2]) * PW'(e_ff[2][1]);
      m_in[2] = PW'(e_ff[1][2]) * PW'(e_ff[2][0]);
      m_in[3] = PW'(e_ff[1][0]) * PW'(e_ff[2][2]);
      m_in[4] = PW'(e_ff[1][0]) * PW'(e_ff[2][1]);
      m_in[5] = PW'(e_ff[1][1]) * PW'(e_ff[2][0]);
      for (int i = 0; i < 6; i++) begin
         for (int k = 0; k < 3; k++) begin
            sq_in[i][k] = PW'(e_ff[i][k]) * PW'(e_ff[i][k]);
         end
      end
   end

   always_comb begin
      c_in[0] = CW'(m_ff[0]) - CW'(m_ff[1]);
      c_in[1] = CW'(m_ff[2]) - CW'(m_ff[3]);
      c_in[2] = CW'(m_ff[4]) - CW'(m_ff[5]);
      for (int i = 0; i < 6; i++) begin
         es_in[i] = ESW'($unsigned(sq_ff[i][0])) + ESW'($unsigned(sq_ff[i][1]))
                  + ESW'($unsigned(sq_ff[i][2]));
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         t_in[k] = TW'(e1b_ff[k]) * TW'(c_ff[k]);
      end
      sum_in = SUM_W'(es_ff[0]) + SUM_W'(es_ff[1]) + SUM_W'(es_ff[2])
             + SUM_W'(es_ff[3]) + SUM_W'(es_ff[4]) + SUM_W'(es_ff[5]);
   end

   always_comb begin
      tp     = AW'(t_ff[0]) + AW'(t_ff[1]) + AW'(t_ff[2]);
      tp_abs = (tp < 0) ? $unsigned(-tp) : $unsigned(tp);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      e_ff    <= e_in;
      m_ff    <= m_in;
      sq_ff   <= sq_in;
      e1a_ff  <= e_ff[0];
      c_ff    <= c_in;
      es_ff   <= es_in;
      e1b_ff  <= e1a_ff;
      t_ff    <= t_in;
      sum4_ff <= sum_in;
      top_ff  <= tqm_pkg::SIXV_W'(tp_abs);
      sum5_ff <= sum4_ff;
   end

   assign out_valid = v5_ff;
   assign out_top   = top_ff;
   assign out_sum   = sum5_ff;

endmodule
`default_nettype wire

// ----- rtl/core/tqm_isqrt.sv -----
// tqm_isqrt: pipelined integer square root, one root bit per stage
// depends on tqm_pkg; carries the triple product alongside
`default_nettype none
module tqm_isqrt #(
   parameter int ROOT_W = 19
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire logic [2*ROOT_W-1:0]       in_sum,
   input  wire logic [tqm_pkg::SIXV_W-1:0] in_top,
   output logic                           out_valid,
   output logic [ROOT_W-1:0]              out_root,
   output logic [tqm_pkg::SIXV_W-1:0]     out_top
);
   localparam int XW   = 2*ROOT_W;
   localparam int REMW = ROOT_W + 2;

   logic [XW-1:0]               x_src    [0:ROOT_W-1];
   logic [REMW-1:0]             rem_src  [0:ROOT_W-1];
   logic [ROOT_W-1:0]           root_src [0:ROOT_W-1];
   logic [tqm_pkg::SIXV_W-1:0]  top_src  [0:ROOT_W-1];
   logic                        val_src  [0:ROOT_W-1];

   logic [XW-1:0]               x_in    [0:ROOT_W-1];
   logic [REMW-1:0]             rem_in  [0:ROOT_W-1];
   logic [ROOT_W-1:0]           root_in [0:ROOT_W-1];

   logic [XW-1:0]               x_ff    [0:ROOT_W-1];
   logic [REMW-1:0]             rem_ff  [0:ROOT_W-1];
   logic [ROOT_W-1:0]           root_ff [0:ROOT_W-1];
   logic [tqm_pkg::SIXV_W-1:0]  top_ff  [0:ROOT_W-1];
   logic                        val_ff  [0:ROOT_W-1];

   always_comb begin
      x_src[0]    = in_sum;
      rem_src[0]  = '0;
      root_src[0] = '0;
      top_src[0]  = in_top;
      val_src[0]  = in_valid;
      for (int k = 1; k < ROOT_W; k++) begin
         x_src[k]    = x_ff[k-1];
         rem_src[k]  = rem_ff[k-1];
         root_src[k] = root_ff[k-1];
         top_src[k]  = top_ff[k-1];
         val_src[k]  = val_ff[k-1];
      end
   end

   // restoring digit step: bring down two bits, try 4*root+1
   always_comb begin
      for (int k = 0; k < ROOT_W; k++) begin
         logic [REMW-1:0] rem_sh;
         logic [REMW-1:0] trial;
         logic            ge;
         rem_sh     = {rem_src[k][ROOT_W-1:0], x_src[k][XW-1 -: 2]};
         trial      = {root_src[k], 2'b01};
         ge         = (rem_sh >= trial);
         rem_in[k]  = ge ? (rem_sh - trial) : rem_sh;
         root_in[k] = {root_src[k][ROOT_W-2:0], ge};
         x_in[k]    = x_src[k] << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ROOT_W; k++) begin
            val_ff[k] <= 1'b0;
         end
      end else begin
         val_ff <= val_src;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      top_ff  <= top_src;
   end

   assign out_valid = val_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_top   = top_ff[ROOT_W-1];

endmodule
`default_nettype wire

// ----- rtl/core/tqm_div.sv -----
// tqm_div: pipelined restoring divider, one quotient bit per stage
// depends on tqm_pkg; builds the result item at its last stage
`default_nettype none
module tqm_div #(
   parameter int ROOT_W        = 19,
   parameter int FRACTION_BITS = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic [ROOT_W-1:0]          in_root,
   input  wire logic [tqm_pkg::SIXV_W-1:0] in_top,
   output logic                            out_valid,
   output tqm_pkg::rsp_type                out_data
);
   localparam int NW = tqm_pkg::SIXV_W + FRACTION_BITS;
   localparam int QW = tqm_pkg::QUAL_W;

   logic [NW-1:0]               n_src   [0:NW-1];
   logic [ROOT_W-1:0]           rem_src [0:NW-1];
   logic [ROOT_W-1:0]           d_src   [0:NW-1];
   logic [QW-1:0]               q_src   [0:NW-1];
   logic [tqm_pkg::SIXV_W-1:0]  top_src [0:NW-1];
   logic                        dg_src  [0:NW-1];
   logic                        val_src [0:NW-1];

   logic [NW-1:0]               n_in   [0:NW-1];
   logic [ROOT_W-1:0]           rem_in [0:NW-1];
   logic [QW-1:0]               q_in   [0:NW-1];

   logic [NW-1:0]               n_ff   [0:NW-1];
   logic [ROOT_W-1:0]           rem_ff [0:NW-1];
   logic [ROOT_W-1:0]           d_ff   [0:NW-1];
   logic [QW-1:0]               q_ff   [0:NW-1];
   logic [tqm_pkg::SIXV_W-1:0]  top_ff [0:NW-1];
   logic                        dg_ff  [0:NW-1];
   logic                        val_ff [0:NW-1];

   always_comb begin
      n_src[0]   = NW'(in_top) << FRACTION_BITS;
      rem_src[0] = '0;
      d_src[0]   = in_root;
      q_src[0]   = '0;
      top_src[0] = in_top;
      dg_src[0]  = (in_root == '0);
      val_src[0] = in_valid;
      for (int k = 1; k < NW; k++) begin
         n_src[k]   = n_ff[k-1];
         rem_src[k] = rem_ff[k-1];
         d_src[k]   = d_ff[k-1];
         q_src[k]   = q_ff[k-1];
         top_src[k] = top_ff[k-1];
         dg_src[k]  = dg_ff[k-1];
         val_src[k] = val_ff[k-1];
      end
   end

   // remainder stays below the divisor, so it fits the divisor width
   always_comb begin
      for (int k = 0; k < NW; k++) begin
         logic [ROOT_W:0] rem_sh;
         logic [ROOT_W:0] diff;
         logic            ge;
         rem_sh    = {rem_src[k], n_src[k][NW-1]};
         diff      = rem_sh - {1'b0, d_src[k]};
         ge        = (rem_sh >= {1'b0, d_src[k]});
         rem_in[k] = ge ? diff[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
         q_in[k]   = {q_src[k][QW-2:0], ge};
         n_in[k]   = n_src[k] << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NW; k++) begin
            val_ff[k] <= 1'b0;
         end
      end else begin
         val_ff <= val_src;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      rem_ff <= rem_in;
      d_ff   <= d_src;
      q_ff   <= q_in;
      top_ff <= top_src;
      dg_ff  <= dg_src;
   end

   always_comb begin
      out_data.six_volume = top_ff[NW-1];
      out_data.quality    = dg_ff[NW-1] ? '0 : q_ff[NW-1];
      out_data.degenerate = dg_ff[NW-1];
   end

   assign out_valid = val_ff[NW-1];

endmodule
`default_nettype wire

// ----- rtl/core/tetrahedron_quality_metric.sv -----
// an accepted item passes tqm_geom, tqm_isqrt and tqm_div in that order to rsp_valid
// throughput: one item per cycle; busy stays low, the pipeline never stalls
// the root and divider pipelines retire one bit per stage and set the depth
// synchronous reset clears only the valid bits; items in flight are dropped
// depends on tqm_pkg, tqm_geom, tqm_isqrt, tqm_div
`default_nettype none
module tetrahedron_quality_metric #(
   parameter int COORD_BITS    = 16,
   parameter int FRACTION_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire tqm_pkg::req_type  req_data,
   output logic                   rsp_valid,
   output tqm_pkg::rsp_type       rsp_data
);
   localparam int SUM_W  = 2*(COORD_BITS+1) + 4;
   localparam int ROOT_W = SUM_W / 2;
   localparam int LAT    = 5 + ROOT_W + tqm_pkg::SIXV_W + FRACTION_BITS;

   logic                        accept;
   logic                        g_valid;
   logic [tqm_pkg::SIXV_W-1:0]  g_top;
   logic [SUM_W-1:0]            g_sum;
   logic                        r_valid;
   logic [ROOT_W-1:0]           r_root;
   logic [tqm_pkg::SIXV_W-1:0]  r_top;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   tqm_geom #(
      .COORD_BITS(COORD_BITS)
   ) u_geom (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_data  (req_data),
      .out_valid(g_valid),
      .out_top  (g_top),
      .out_sum  (g_sum)
   );

   tqm_isqrt #(
      .ROOT_W(ROOT_W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (g_valid),
      .in_sum   (g_sum),
      .in_top   (g_top),
      .out_valid(r_valid),
      .out_root (r_root),
      .out_top  (r_top)
   );

   tqm_div #(
      .ROOT_W       (ROOT_W),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (r_valid),
      .in_root  (r_root),
      .in_top   (r_top),
      .out_valid(rsp_valid),
      .out_data (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("accepted item did not come out after the pipeline latency");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("result without a matching accepted item");

   a_degen_quality: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.degenerate) |-> (rsp_data.quality == '0))
      else $error("degenerate item has nonzero quality");

   a_degen_volume: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.degenerate) |-> (rsp_data.six_volume == '0))
      else $error("degenerate item has nonzero volume");
`endif

endmodule
`default_nettype wire

// ----- test/tqm_checker.sv -----
// tqm_checker: watches the item and result channels of tetrahedron_quality_metric
// predicts volume and quality per accepted item and compares; depends on tqm_pkg
module tqm_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire tqm_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire tqm_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    pending_count,
   output int                    result_count,
   output int                    degenerate_count
);
   timeunit 1ns;
   timeprecision 1ps;

   tqm_pkg::rsp_type metric_queue[$];

   function automatic logic [63:0] floor_root(logic [127:0] x);
      logic [127:0] acc;
      logic [127:0] trial;
      logic [63:0]  r;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         trial = r | (64'd1 << b);
         acc = trial * trial;
         if (acc <= x) r = trial[63:0];
      end
      return r;
   endfunction

   function automatic tqm_pkg::rsp_type predict_metric(tqm_pkg::req_type t);
      tqm_pkg::rsp_type o;
      longint p[4][3];
      longint e1[3], e2[3], e3[3];
      longint d, cx, cy, cz, tp;
      logic [127:0] edge_sum;
      logic [127:0] top;
      logic [63:0]  r;
      int pr[6][2];
      p[0][0] = t.v0_x; p[0][1] = t.v0_y; p[0][2] = t.v0_z;
      p[1][0] = t.v1_x; p[1][1] = t.v1_y; p[1][2] = t.v1_z;
      p[2][0] = t.v2_x; p[2][1] = t.v2_y; p[2][2] = t.v2_z;
      p[3][0] = t.v3_x; p[3][1] = t.v3_y; p[3][2] = t.v3_z;
      for (int k = 0; k < 3; k++) begin
         e1[k] = p[1][k] - p[0][k];
         e2[k] = p[2][k] - p[0][k];
         e3[k] = p[3][k] - p[0][k];
      end
      cx = e2[1] * e3[2] - e2[2] * e3[1];
      cy = e2[2] * e3[0] - e2[0] * e3[2];
      cz = e2[0] * e3[1] - e2[1] * e3[0];
      tp = e1[0] * cx + e1[1] * cy + e1[2] * cz;
      top = (tp < 0) ? 128'(-tp) : 128'(tp);
      // six vertex pairs
      pr = '{'{1, 0}, '{2, 0}, '{3, 0}, '{1, 2}, '{1, 3}, '{2, 3}};
      edge_sum = 0;
      for (int e = 0; e < 6; e++)
         for (int k = 0; k < 3; k++) begin
            d = p[pr[e][0]][k] - p[pr[e][1]][k];
            edge_sum += 128'(d * d);
         end
      r = floor_root(edge_sum);
      o.six_volume = top[54:0];
      if (r == 0) begin
         o.quality = '0;
         o.degenerate = 1'b1;
      end else begin
         o.quality = 47'((top << 8) / r);
         o.degenerate = 1'b0;
      end
      return o;
   endfunction

   assign pending_count = metric_queue.size();

   always @(posedge clock) begin
      tqm_pkg::rsp_type want;
      if (reset) begin
         metric_queue.delete();
         fail_count <= 0;
         result_count <= 0;
         degenerate_count <= 0;
      end else begin
         if (start && !busy)
            metric_queue.insert(metric_queue.size(), predict_metric(req_data));
         if (rsp_valid) begin
            result_count <= result_count + 1;
            if (rsp_data.degenerate) degenerate_count <= degenerate_count + 1;
            if (metric_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = metric_queue.pop_front();
               if (want != rsp_data) begin
                  if (fail_count < 10)
                     $display("mismatch: expected vol %0d q %0d deg %0b, got vol %0d q %0d deg %0b",
                        want.six_volume, want.quality, want.degenerate,
                        rsp_data.six_volume, rsp_data.quality, rsp_data.degenerate);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ----- test/tb.sv -----
// tb: drives tetrahedra into tetrahedron_quality_metric and gives the verdict
// depends on tqm_pkg, the rtl and tqm_checker
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 87;
   localparam int RANDOM_ITEMS = 1100;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy, rsp_valid;
   tqm_pkg::req_type req_data = '0;
   tqm_pkg::rsp_type rsp_data;
   int fail_count, pending_count, result_count, degenerate_count;
   int cycle_count = 0;
   int item_count = 0;
   tqm_pkg::req_type directed[$];

   always #6 clock = ~clock;

   tetrahedron_quality_metric dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   tqm_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .result_count(result_count), .degenerate_count(degenerate_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout");
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic tqm_pkg::req_type make_tet(int kind);
      tqm_pkg::req_type t;
      logic [15:0] base[3];
      int span;
      t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if (kind == 0) return t;
      // small or mid sized tet near a random base point, sometimes flat
      span = (kind == 1) ? 4 : 2000;
      for (int k = 0; k < 3; k++) base[k] = 16'($urandom);
      t.v0_x = base[0]; t.v0_y = base[1]; t.v0_z = base[2];
      t.v1_x = base[0] + 16'($urandom_range(0, span)); t.v1_y = base[1];
      t.v1_z = base[2] + 16'($urandom_range(0, span));
      t.v2_x = base[0]; t.v2_y = base[1] + 16'($urandom_range(0, span));
      t.v2_z = base[2] - 16'($urandom_range(0, span));
      t.v3_x = base[0] - 16'($urandom_range(0, span));
      t.v3_y = base[1] + 16'($urandom_range(0, span));
      t.v3_z = ($urandom_range(0, 3) == 0) ? base[2] : base[2] + 16'($urandom_range(0, span));
      return t;
   endfunction

   function automatic void add_directed(tqm_pkg::req_type t);
      directed.insert(directed.size(), t);
   endfunction

   // send one item, holding start across accepting edges
   task automatic send_item(tqm_pkg::req_type t, bit keep_on);
      start <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (busy);
      item_count++;
      if (!keep_on) start <= 1'b0;
   endtask

   initial begin
      tqm_pkg::req_type t;
      int gap;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // all vertices equal, at zero, min and max
      add_directed('0);
      add_directed({12{16'h8000}});
      add_directed({12{16'h7fff}});
      // extremes: corners of the coordinate cube
      t = '0;
      t.v0_x = 16'h8000; t.v0_y = 16'h8000; t.v0_z = 16'h8000;
      t.v1_x = 16'h7fff; t.v1_y = 16'h8000; t.v1_z = 16'h8000;
      t.v2_x = 16'h8000; t.v2_y = 16'h7fff; t.v2_z = 16'h8000;
      t.v3_x = 16'h8000; t.v3_y = 16'h8000; t.v3_z = 16'h7fff;
      add_directed(t);
      t.v0_x = 16'h7fff; t.v1_x = 16'h8000;
      add_directed(t);
      // alternating extremes, then alternating -1 and 0
      add_directed({6{16'h8000, 16'h7fff}});
      add_directed({6{16'h7fff, 16'h8000}});
      add_directed({12{16'hffff}} ^ {6{32'h0000_ffff}});
      // flat tet with distinct vertices
      t = '0;
      t.v1_x = 1; t.v2_y = 1; t.v3_x = 5; t.v3_y = 7;
      add_directed(t);
      // unit tet
      t.v3_x = 0; t.v3_y = 0; t.v3_z = 1;
      add_directed(t);
      // one vertex apart, the other three coincident
      t = '0; t.v3_z = 16'h8000;
      add_directed(t);
      for (int i = 0; i < directed.size(); i++) send_item(directed[i], 1'b1);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         gap = $urandom_range(0, 3);
         send_item(make_tet($urandom_range(0, 2)), gap != 0 || i >= RANDOM_ITEMS - 150);
         if (gap == 0 && i < RANDOM_ITEMS - 150) begin
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
      end
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("sent %0d tetrahedra, %0d results checked, %0d degenerate",
         item_count, result_count, degenerate_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
